@@ hw/rtl/mm3_pkg.sv @@
// Package: shared types and constants for the murmur3 x86_32 hash block.
`default_nettype none
package mm3_pkg;

  localparam logic [31:0] C1      = 32'hcc9e2d51;
  localparam logic [31:0] C2      = 32'h1b873593;
  localparam logic [31:0] MERGE_K = 32'he6546b64;
  localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;
  localparam logic [2:0]  FULL_COUNT = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL1,
    OP_MUL2,
    OP_MERGE,
    OP_FMIX1,
    OP_FMIX2,
    OP_FMIX3
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/mm3_ctrl.sv @@
// Controller: sequences load, scramble, merge and finalization steps.
`default_nettype none
module mm3_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire mm3_pkg::status_t sts,
  output mm3_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MERGE,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = mm3_pkg::OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = mm3_pkg::OP_LOAD;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.op     = mm3_pkg::OP_MUL1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op     = mm3_pkg::OP_MUL2;
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.op     = mm3_pkg::OP_MERGE;
        state_next = sts.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.op     = mm3_pkg::OP_FMIX1;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op     = mm3_pkg::OP_FMIX2;
        state_next = ST_FIN3;
      end
      ST_FIN3: begin
        if (!sts.out_busy) begin
          cmd.op     = mm3_pkg::OP_FMIX3;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mm3_datapath.sv @@
// Datapath: seed, running hash, byte total, shared multiplier, output register.
`default_nettype none
module mm3_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mm3_pkg::cmd_t    cmd,
  output mm3_pkg::status_t      sts,
  input  wire logic [31:0]      data_word,
  input  wire logic [2:0]       byte_count,
  input  wire logic             last_word,
  input  wire logic             cfg_valid,
  input  wire logic [31:0]      seed,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [31:0]           hash_value
);

  logic [31:0] seed_value;
  logic [31:0] scr;
  logic [31:0] hash_acc;
  logic [31:0] total;
  logic [2:0]  count;
  logic        last;
  logic        in_key;

  logic [2:0]  count_eff;
  logic [31:0] mask;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] product;
  logic [31:0] mix;
  logic [31:0] rot;
  logic [31:0] merged;
  logic [31:0] fin_x;

  always_comb begin
    count_eff = byte_count;
    if (!last_word || byte_count > mm3_pkg::FULL_COUNT) begin
      count_eff = mm3_pkg::FULL_COUNT;
    end
    case (count_eff)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign fin_x = hash_acc ^ total;

  always_comb begin
    mul_a = scr;
    mul_b = mm3_pkg::C1;
    case (cmd.op)
      mm3_pkg::OP_MUL2: begin
        mul_a = {scr[16:0], scr[31:17]};
        mul_b = mm3_pkg::C2;
      end
      mm3_pkg::OP_FMIX1: begin
        mul_a = fin_x ^ {16'h0000, fin_x[31:16]};
        mul_b = mm3_pkg::FMIX_C1;
      end
      mm3_pkg::OP_FMIX2: begin
        mul_a = hash_acc ^ {13'h0000, hash_acc[31:13]};
        mul_b = mm3_pkg::FMIX_C2;
      end
      default: begin
        mul_a = scr;
        mul_b = mm3_pkg::C1;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  always_comb begin
    mix    = hash_acc ^ scr;
    rot    = {mix[18:0], mix[31:19]};
    merged = (count == mm3_pkg::FULL_COUNT) ? (rot + {rot[29:0], 2'b00} + mm3_pkg::MERGE_K)
                                            : mix;
  end

  assign sts.last     = last;
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= 32'h0;
      hash_acc   <= 32'h0;
      total      <= 32'h0;
      in_key     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed_value <= seed;
      end
      if (cmd.op == mm3_pkg::OP_FMIX3) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        mm3_pkg::OP_LOAD: begin
          scr   <= data_word & mask;
          count <= count_eff;
          last  <= last_word;
          if (!in_key) begin
            hash_acc <= seed_value;
          end
          in_key <= 1'b1;
        end
        mm3_pkg::OP_MUL1, mm3_pkg::OP_MUL2: begin
          scr <= product;
        end
        mm3_pkg::OP_MERGE: begin
          hash_acc <= merged;
          total    <= total + {29'h0, count};
        end
        mm3_pkg::OP_FMIX1, mm3_pkg::OP_FMIX2: begin
          hash_acc <= product;
        end
        mm3_pkg::OP_FMIX3: begin
          hash_value <= hash_acc ^ {16'h0000, hash_acc[31:16]};
          total      <= 32'h0;
          in_key     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/murmur3_32_hash_top.sv @@
// Top level: murmur3 x86_32 hash engine, controller plus datapath.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_stall, data_word, byte_count,|  in
//           | last_word                                 |
//   out     | out_valid, out_stall, hash_value          | out
//   cfg     | cfg_valid, cfg_ready, seed                |  in
//
// Each word is loaded, passed twice through the one shared 32x32
// multiplier, then merged. A last word adds the finalization steps, two of
// them on the same multiplier. in_stall is high from the cycle after a
// request is taken until the item is done. A held output stalls only the
// final step of the next key. Reset is synchronous and sets the seed to 0.
`default_nettype none
module murmur3_32_hash_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      hash_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] seed
);

  mm3_pkg::cmd_t    cmd;
  mm3_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  mm3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mm3_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .cfg_valid  (cfg_valid),
    .seed       (seed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule
`default_nettype wire

@@ tb/tb_murmur3_32_hash_top.sv @@
// Testbench for murmur3_32_hash_top: a directed table, then random keys checked against a local hash.
`default_nettype none
module tb_murmur3_32_hash_top;

  localparam logic [2:0] WORD_BYTES   = 3'd4;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         SQUEEZE_AT   = 30;
  localparam int         SQUEEZE_LEN  = 400;
  localparam int         PHASE_ITEMS  = 158;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        fin;
    logic        known;
    logic [31:0] hash;
  } key_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] hash_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] seed = '0;

  logic [31:0] key_seed;
  logic [31:0] run_hash;
  logic [31:0] byte_sum;
  bit          key_open;

  logic [31:0] hash_q[$];
  int          miss_count = 0;
  int          hashes_seen = 0;
  bit          calm = 1'b0;

  key_row_t dir_rows [20] = '{
    '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
    '{32'h74736574, 3'd4, 1'b1, 1'b1, 32'hba6bd213},
    '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0},
    '{32'ha5a5a5a5, 3'd2, 1'b1, 1'b0, 32'h0},
    '{32'hdeadbeef, 3'd3, 1'b1, 1'b0, 32'h0},
    '{32'hffffffff, 3'd5, 1'b1, 1'b0, 32'h0},
    '{32'h00000000, 3'd6, 1'b1, 1'b0, 32'h0},
    '{32'h7fffffff, 3'd7, 1'b1, 1'b0, 32'h0},
    '{32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    '{32'h12345678, 3'd2, 1'b0, 1'b0, 32'h0},
    '{32'h9abcdef0, 3'd7, 1'b0, 1'b0, 32'h0},
    '{32'h0f0f0f0f, 3'd3, 1'b1, 1'b0, 32'h0},
    '{32'h11111111, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
    '{32'h80000000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h00000001, 3'd1, 1'b1, 1'b0, 32'h0},
    '{32'hfffffffe, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h55555555, 3'd4, 1'b1, 1'b0, 32'h0}
  };

  murmur3_32_hash_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .seed       (seed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] k);
    logic [31:0] t;
    t = k * 32'hcc9e2d51;
    t = rotl(t, 15);
    return t * 32'h1b873593;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * 32'h85ebca6b;
    t = t ^ (t >> 13);
    t = t * 32'hc2b2ae35;
    return t ^ (t >> 16);
  endfunction

  // Advances the key state by one word; done is set when the key closes.
  task automatic hash_step(input logic [31:0] w, input logic [2:0] c, input logic fin,
                           output bit done, output logic [31:0] h_out);
    logic [31:0] h;
    logic [31:0] mask;
    logic [2:0]  n;
    if (!key_open) begin
      run_hash = key_seed;
      key_open = 1'b1;
    end
    n = (c > WORD_BYTES || !fin) ? WORD_BYTES : c;
    h = run_hash;
    byte_sum = byte_sum + 32'(n);
    if (n == WORD_BYTES) begin
      h = rotl(h ^ scramble(w), 13);
      h = h * 32'd5 + 32'he6546b64;
    end else begin
      mask = (n == 3'd0) ? 32'h0 : (32'hffffffff >> (32 - 8 * int'(n)));
      h = h ^ scramble(w & mask);
    end
    done = fin;
    h_out = '0;
    if (!fin) begin
      run_hash = h;
    end else begin
      h_out = avalanche(h ^ byte_sum);
      run_hash = key_seed;
      byte_sum = '0;
      key_open = 1'b0;
    end
  endtask

  task automatic note_miss(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    miss_count++;
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One request on the input channel; for a last word the expected hash is queued when it is taken.
  task automatic push_word(input logic [31:0] w, input logic [2:0] c, input logic fin,
                           input logic known, input logic [31:0] known_hash);
    int          gap;
    bit          done;
    logic [31:0] h;
    gap = pick_gap(calm);
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    data_word  = w;
    byte_count = c;
    last_word  = fin;
    do @(posedge clk); while (in_stall);
    hash_step(w, c, fin, done, h);
    if (done)
      hash_q.push_back(known ? known_hash : h);
  endtask

  task automatic drain_input;
    @(negedge clk);
    in_valid = 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(input logic [31:0] v);
    drain_input();
    @(negedge clk);
    cfg_valid = 1'b1;
    seed      = v;
    do @(posedge clk); while (!cfg_ready);
    key_seed = v;
    if (!key_open)
      run_hash = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_data;
    int r;
    r = $urandom_range(0, 15);
    if (r == 0)
      return 32'h0;
    if (r == 1)
      return 32'hffffffff;
    return $urandom;
  endfunction

  // Receiver: random hold-offs, one long hold once SQUEEZE_AT hashes have been seen.
  initial begin
    int  hold;
    bit  squeezed;
    bit  sink_calm;
    int  r;
    hold = 0;
    squeezed = 1'b0;
    sink_calm = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0)
        sink_calm = !sink_calm;
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        if (!sink_calm) begin
          r = $urandom_range(0, 99);
          if (r >= 95)
            hold = $urandom_range(8, 40);
          else if (r >= 70)
            hold = $urandom_range(1, 3);
        end
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (hash_q.size() == 0) begin
          note_miss("unexpected hash", hash_value, 32'h0);
        end else begin
          if (hash_value !== hash_q[0])
            note_miss("hash_value", hash_value, hash_q[0]);
          void'(hash_q.pop_front());
        end
        hashes_seen++;
        if (!squeezed && hashes_seen == SQUEEZE_AT) begin
          squeezed = 1'b1;
          hold = SQUEEZE_LEN;
        end
      end
    end
  end

  initial begin
    logic [31:0] phase_seed [6];
    int          phase_items;
    int          nw;
    logic [2:0]  c;
    key_seed = '0;
    run_hash = '0;
    byte_sum = '0;
    key_open = 1'b0;
    phase_seed = '{32'h00000000, 32'hffffffff, $urandom, 32'h00000001, 32'h80000000,
                   $urandom};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      push_word(dir_rows[i].word, dir_rows[i].cnt, dir_rows[i].fin, dir_rows[i].known,
                dir_rows[i].hash);

    for (int p = 0; p < 6; p++) begin
      load_seed(phase_seed[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        calm = ($urandom_range(0, 3) == 0);
        nw = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int j = 0; j < nw; j++) begin
          if (j == nw - 1) begin
            c = 3'($urandom_range(0, 7));
            push_word(pick_data(), c, 1'b1, 1'b0, 32'h0);
          end else begin
            c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : WORD_BYTES;
            push_word(pick_data(), c, 1'b0, 1'b0, 32'h0);
          end
        end
        phase_items += nw;
      end
      calm = 1'b0;
    end

    drain_input();
    repeat (30) @(posedge clk);
    if (miss_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/mm3_pkg.sv
hw/rtl/mm3_ctrl.sv
hw/rtl/mm3_datapath.sv
hw/rtl/murmur3_32_hash_top.sv
tb/tb_murmur3_32_hash_top.sv
